@@ hw/rtl/pte_pkg.sv @@
// ----------------------------------------------------------------------------
// Pre-integration table engine package
// Shared beat types, command and status structs and constants.
// ----------------------------------------------------------------------------
package pte_pkg;

    localparam int unsigned CW = 27;
    localparam int unsigned AW = 17;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef struct packed {
        logic       opcode;
        logic [7:0] entry_index;
        logic [7:0] entry_red;
        logic [7:0] entry_green;
        logic [7:0] entry_blue;
        logic [7:0] entry_alpha;
        logic [7:0] back_scalar;
        logic [7:0] front_scalar;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_out_beat;

    // Controller to datapath.
    typedef struct packed {
        logic capture;     // latch the input beat
        logic rd_prev;     // read previous entry and prefixes
        logic wr_load;     // write entry and prefix of a load
        logic rd_hi;       // read entries at the larger scalar
        logic rd_lo;       // read entries at the smaller scalar
        logic setup;       // form numerators and divisors
        logic div_step;    // one restoring division step
        logic exp_start;   // set up the exponential
        logic exp_step;    // one Taylor or squaring step
        logic finish;      // load the output register
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic is_valid_load;
        logic exp_done;
    } t_sts;

endpackage

@@ hw/rtl/pte_datapath.sv @@
// ----------------------------------------------------------------------------
// Pre-integration table engine datapath
// Table memories, prefix arithmetic, bit-serial dividers and exponential.
// ----------------------------------------------------------------------------
module pte_datapath #(
    parameter int unsigned TABLE_SIZE = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pte_pkg::t_in_beat i_beat,
    input  pte_pkg::t_cmd     i_cmd,
    output pte_pkg::t_sts     o_sts,
    output pte_pkg::t_out_beat o_result
);
    import pte_pkg::*;

    localparam int unsigned IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    logic [31:0]   m_entry [TABLE_SIZE];
    logic [CW-1:0] m_red   [TABLE_SIZE];
    logic [CW-1:0] m_green [TABLE_SIZE];
    logic [CW-1:0] m_blue  [TABLE_SIZE];
    logic [AW-1:0] m_opa   [TABLE_SIZE];

    t_in_beat      r_beat;
    logic [IW-1:0] r_hi, r_lo, r_idx;
    logic [7:0]    r_d;
    logic [31:0]   r_ent_a;
    logic [CW-1:0] r_red_a, r_green_a, r_blue_a;
    logic [AW-1:0] r_opa_a;
    logic [31:0]   r_ent_b;
    logic [CW-1:0] r_red_b, r_green_b, r_blue_b;
    logic [AW-1:0] r_opa_b;

    // Dividers: four quotients share one step counter; 27 steps.
    logic [CW-1:0] r_num [4];
    logic [CW:0]   r_rem [4];
    logic [CW-1:0] r_quo [4];
    logic [CW-1:0] r_div [4];
    logic          r_neg [4];
    logic          r_sat0;

    logic [31:0]   r_z;
    logic [31:0]   r_term;
    logic [31:0]   r_prod;
    logic [32:0]   r_s;
    logic [3:0]    r_k;
    logic          r_ph;
    logic [2:0]    r_sq;
    logic          r_in_sq;
    logic          r_exp_done;
    t_out_beat     r_out;

    logic [IW-1:0] idx_in, b_sat, f_sat;
    logic [7:0]    b_cl, f_cl;
    logic [8:0]    sa;

    function automatic logic [7:0] sat_idx(input logic [7:0] v);
        if (int'(v) >= TABLE_SIZE) begin
            return 8'(TABLE_SIZE - 1);
        end
        return v;
    endfunction

    assign b_cl   = sat_idx(r_beat.back_scalar);
    assign f_cl   = sat_idx(r_beat.front_scalar);
    assign b_sat  = b_cl[IW-1:0];
    assign f_sat  = f_cl[IW-1:0];
    assign idx_in = r_beat.entry_index[IW-1:0];
    assign sa     = {1'b0, r_ent_a[31:24]} + {1'b0, r_beat.entry_alpha};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_beat <= i_beat;
        end
        if (i_cmd.rd_prev) begin
            r_idx   <= idx_in;
            r_ent_a <= m_entry[idx_in - IW'(1)];
            r_red_a <= m_red[idx_in - IW'(1)];
            r_green_a <= m_green[idx_in - IW'(1)];
            r_blue_a  <= m_blue[idx_in - IW'(1)];
            r_opa_a   <= m_opa[idx_in - IW'(1)];
            r_hi <= (b_cl > f_cl) ? b_sat : f_sat;
            r_lo <= (b_cl > f_cl) ? f_sat : b_sat;
            r_d  <= (b_cl > f_cl) ? (b_cl - f_cl) : (f_cl - b_cl);
        end
        if (i_cmd.wr_load) begin
            m_entry[r_idx] <= {r_beat.entry_alpha, r_beat.entry_blue,
                               r_beat.entry_green, r_beat.entry_red};
            if (r_idx == '0) begin
                m_red[r_idx] <= '0;
                m_green[r_idx] <= '0;
                m_blue[r_idx] <= '0;
                m_opa[r_idx] <= '0;
            end else begin
                m_red[r_idx] <= r_red_a + CW'({1'b0, r_ent_a[7:0]}
                    + {1'b0, r_beat.entry_red}) * CW'(sa);
                m_green[r_idx] <= r_green_a + CW'({1'b0, r_ent_a[15:8]}
                    + {1'b0, r_beat.entry_green}) * CW'(sa);
                m_blue[r_idx] <= r_blue_a + CW'({1'b0, r_ent_a[23:16]}
                    + {1'b0, r_beat.entry_blue}) * CW'(sa);
                m_opa[r_idx] <= r_opa_a + AW'(sa);
            end
        end
        if (i_cmd.rd_hi) begin
            r_ent_a   <= m_entry[r_hi];
            r_red_a   <= m_red[r_hi];
            r_green_a <= m_green[r_hi];
            r_blue_a  <= m_blue[r_hi];
            r_opa_a   <= m_opa[r_hi];
        end
        if (i_cmd.rd_lo) begin
            r_ent_b   <= m_entry[r_lo];
            r_red_b   <= m_red[r_lo];
            r_green_b <= m_green[r_lo];
            r_blue_b  <= m_blue[r_lo];
            r_opa_b   <= m_opa[r_lo];
        end
    end

    logic [CW:0]   dr, dg, db;
    logic [AW:0]   dop;
    logic [17:0]   m510;
    logic [CW-1:0] d1020;
    assign dr    = {1'b0, r_red_a} - {1'b0, r_red_b};
    assign dg    = {1'b0, r_green_a} - {1'b0, r_green_b};
    assign db    = {1'b0, r_blue_a} - {1'b0, r_blue_b};
    assign dop   = {1'b0, r_opa_a} - {1'b0, r_opa_b};
    assign m510  = 18'(r_d) * 18'd510;
    assign d1020 = CW'(r_d) * CW'(1020);

    logic [CW:0] trial [4];
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            trial[j] = {r_rem[j][CW-1:0], r_num[j][CW-1]} - {1'b0, r_div[j]};
        end
    end

    // The opacity dividend is the opacity sum shifted left by 16. Its quotient
    // fits in 19 bits, so the top bits start in the remainder and 27 steps
    // give the whole quotient.
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            if (r_d != '0) begin
                r_num[0] <= dr[CW-1:0];  r_neg[0] <= dr[CW];
                r_num[1] <= dg[CW-1:0];  r_neg[1] <= dg[CW];
                r_num[2] <= db[CW-1:0];  r_neg[2] <= db[CW];
                r_neg[3] <= dop[AW];
                r_rem[3] <= (CW+1)'(dop[AW-1:CW-16]);
                r_num[3] <= {dop[CW-17:0], 16'd0};
                for (int j = 0; j < 3; j++) r_div[j] <= d1020;
                r_div[3] <= CW'(m510);
                r_sat0 <= !dop[AW] && (35'(dop[AW-1:0]) >= 35'(m510) * 35'd6);
            end else begin
                r_num[0] <= CW'(r_ent_b[7:0]) * CW'(r_ent_b[31:24]);
                r_num[1] <= CW'(r_ent_b[15:8]) * CW'(r_ent_b[31:24]);
                r_num[2] <= CW'(r_ent_b[23:16]) * CW'(r_ent_b[31:24]);
                r_rem[3] <= '0;
                r_num[3] <= CW'({r_ent_b[31:24], 16'd0});
                for (int j = 0; j < 4; j++) r_neg[j] <= 1'b0;
                for (int j = 0; j < 3; j++) r_div[j] <= CW'(255);
                r_div[3] <= CW'(255);
                r_sat0 <= 1'b0;
            end
            for (int j = 0; j < 3; j++) begin
                r_rem[j] <= '0;
            end
            for (int j = 0; j < 4; j++) begin
                r_quo[j] <= '0;
            end
        end
        if (i_cmd.div_step) begin
            for (int j = 0; j < 4; j++) begin
                if (!trial[j][CW]) begin
                    r_rem[j] <= trial[j];
                    r_quo[j] <= {r_quo[j][CW-2:0], 1'b1};
                end else begin
                    r_rem[j] <= {r_rem[j][CW-1:0], r_num[j][CW-1]};
                    r_quo[j] <= {r_quo[j][CW-2:0], 1'b0};
                end
                r_num[j] <= {r_num[j][CW-2:0], 1'b0};
            end
        end
    end

    // Reciprocals of the Taylor term index, scaled by 2^32 and rounded up,
    // exact for products below 2^27.
    function automatic logic [31:0] recip(input logic [3:0] k);
        case (k)
            4'd2:    return 32'h8000_0000;
            4'd3:    return 32'h5555_5556;
            4'd4:    return 32'h4000_0000;
            4'd5:    return 32'h3333_3334;
            4'd6:    return 32'h2AAA_AAAB;
            4'd7:    return 32'h2492_4925;
            default: return 32'h2000_0000;
        endcase
    endfunction

    // Exponential: seven Taylor terms of two phases each, a summing step and
    // six squarings.
    logic [18:0] xq;
    logic [63:0] tprod;
    logic [63:0] qprod;
    logic [63:0] sq;
    logic [32:0] s_sum;
    assign xq    = r_quo[3][18:0];
    assign tprod = 64'(r_term) * 64'(r_z);
    assign qprod = 64'(r_prod) * 64'(recip(r_k));
    assign sq    = 64'(r_s[31:0]) * 64'(r_s[31:0]);
    assign s_sum = r_s + 33'(r_term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_done <= 1'b0;
        end else if (i_cmd.exp_start) begin
            r_exp_done <= 1'b0;
        end else if (i_cmd.exp_step && r_in_sq && r_sq == 3'd5) begin
            r_exp_done <= 1'b1;
        end
        if (i_cmd.exp_start) begin
            r_z     <= 32'(xq) << 10;
            r_term  <= 32'(xq) << 10;
            r_s     <= 33'h1_0000_0000;
            r_k     <= 4'd2;
            r_ph    <= 1'b0;
            r_sq    <= '0;
            r_in_sq <= 1'b0;
        end else if (i_cmd.exp_step) begin
            if (r_in_sq) begin
                r_s  <= {1'b0, sq[63:32]};
                r_sq <= r_sq + 3'd1;
            end else if (r_k == 4'd9) begin
                r_s     <= (s_sum > 33'h0_FFFF_FFFF) ? 33'h0_FFFF_FFFF : s_sum;
                r_in_sq <= 1'b1;
            end else if (!r_ph) begin
                r_prod <= tprod[63:32];
                r_s    <= r_k[0] ? s_sum : r_s - 33'(r_term);
                r_ph   <= 1'b1;
            end else begin
                r_term <= qprod[63:32];
                r_k    <= r_k + 4'd1;
                r_ph   <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] clip(input logic [CW-1:0] q, input logic neg);
        if (neg) return 8'd0;
        return (q > CW'(255)) ? 8'd255 : q[7:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.out_red   <= clip(r_quo[0], r_neg[0]);
            r_out.out_green <= clip(r_quo[1], r_neg[1]);
            r_out.out_blue  <= clip(r_quo[2], r_neg[2]);
            if (r_neg[3]) r_out.out_alpha <= 8'd255;
            else if (r_sat0) r_out.out_alpha <= 8'd0;
            else r_out.out_alpha <= r_s[31:24];
        end
    end

    assign o_result = r_out;
    assign o_sts.is_query      = (r_beat.opcode == OP_QUERY);
    assign o_sts.is_valid_load = (int'(r_beat.entry_index) < TABLE_SIZE);
    assign o_sts.exp_done      = r_exp_done;

endmodule

@@ hw/rtl/pte_ctrl.sv @@
// ----------------------------------------------------------------------------
// Pre-integration table engine controller
// Sequences loads, table reads, divisions and the exponential.
// ----------------------------------------------------------------------------
module pte_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  pte_pkg::t_sts i_sts,
    output pte_pkg::t_cmd o_cmd
);
    import pte_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DEC   = 9'b000000010,
        S_WR    = 9'b000000100,
        S_RDHI  = 9'b000001000,
        S_RDLO  = 9'b000010000,
        S_SETUP = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_EXP   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_ov, n_ov;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ov    = r_ov && i_out_stall;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.rd_prev = 1'b1;
                if (i_sts.is_query) n_state = S_RDHI;
                else if (i_sts.is_valid_load) n_state = S_WR;
                else n_state = S_IDLE;
            end
            S_WR: begin
                o_cmd.wr_load = 1'b1;
                n_state = S_IDLE;
            end
            S_RDHI: begin
                o_cmd.rd_hi = 1'b1;
                n_state = S_RDLO;
            end
            S_RDLO: begin
                o_cmd.rd_lo = 1'b1;
                n_state = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_cnt = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd26) begin
                    n_state = S_EXP;
                end
                if (r_cnt == 5'd26) o_cmd.exp_start = 1'b0;
            end
            S_EXP: begin
                if (r_cnt == 5'd27) begin
                    o_cmd.exp_start = 1'b1;
                    n_cnt = 5'd28;
                end else begin
                    o_cmd.exp_step = 1'b1;
                    if (i_sts.exp_done) begin
                        o_cmd.exp_step = 1'b0;
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!r_ov) begin
                    o_cmd.finish = 1'b1;
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;

endmodule

@@ hw/rtl/preintegration_table_engine.sv @@
// ----------------------------------------------------------------------------
// Pre-integration table engine
// Top level: controller, datapath and port handshakes.
// ----------------------------------------------------------------------------
// A load beat passes through decode and the table write; an ignored load
// ends after decode. A query beat passes decode, both table reads, setup,
// the 27-step shared restoring divider and the exponential's seven two-phase
// Taylor terms, one summing step and six squarings; it waits longer while
// the previous result is held in the output register. One beat is in work at
// a time; the result register lets the next beat enter while a result waits.
module preintegration_table_engine #(
    parameter int unsigned TABLE_SIZE = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pte_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pte_pkg::t_out_beat o_out_data
);
    import pte_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pte_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall,
        .o_out_valid, .i_out_stall, .i_sts(sts), .o_cmd(cmd)
    );

    pte_datapath #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
        .i_clk, .i_rst_n, .i_beat(i_in_data), .i_cmd(cmd),
        .o_sts(sts), .o_result(o_out_data)
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.wr_load && cmd.div_step)) else $error("load write during divide");
    a_no_cap_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |-> !o_in_stall) else $error("capture while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result lost");

endmodule
